// ===== hw/rtl/svet_pkg.sv =====
// ============================================================================
// svet_pkg - shared types and constants for the segment/edge intersect block
// Holds sizes, request codes and the transfer structs of both channels.
// ============================================================================
`default_nettype none
package svet_pkg;
    localparam int MaxVertices = 1024;
    localparam int MaxEdges    = 1024;
    localparam int CoordBits   = 16;
    localparam int VIdxBits    = $clog2(MaxVertices);
    localparam int EIdxBits    = $clog2(MaxEdges);
    localparam int CntBits     = EIdxBits + 1;
    localparam int DiffBits    = CoordBits + 1;
    localparam int ProdBits    = 2 * DiffBits;
    localparam int DetBits     = ProdBits + 1;

    typedef enum logic [1:0] {
        REQ_WRITE_VERTEX = 2'd0,
        REQ_APPEND_EDGE  = 2'd1,
        REQ_CLEAR_EDGES  = 2'd2,
        REQ_QUERY        = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic [9:0]                  vertex_index;
        logic signed [15:0]          vertex_x;
        logic signed [15:0]          vertex_z;
        logic [9:0]                  edge_first;
        logic [9:0]                  edge_second;
        logic signed [15:0]          query_start_x;
        logic signed [15:0]          query_start_z;
        logic signed [15:0]          query_end_x;
        logic signed [15:0]          query_end_z;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [10:0] edges_held;
    } out_item_t;

    // operands handed to the shared multiply-subtract unit
    typedef struct packed {
        logic signed [DiffBits-1:0] a;
        logic signed [DiffBits-1:0] b;
        logic signed [DiffBits-1:0] c;
        logic signed [DiffBits-1:0] d;
    } mac_op_t;
endpackage
`default_nettype wire

// ===== hw/rtl/svet_ram.sv =====
// ============================================================================
// svet_ram - generic single-port-write, single-read RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none
module svet_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/svet_mac.sv =====
// ============================================================================
// svet_mac - shared cross-product unit
// Computes a*b - c*d: products registered, then subtract.
// ============================================================================
`default_nettype none
module svet_mac (
    input  wire logic                                 clk,
    input  wire svet_pkg::mac_op_t                    op,
    output logic signed [svet_pkg::DetBits-1:0]       result
);
    logic signed [svet_pkg::ProdBits-1:0] p0_reg;
    logic signed [svet_pkg::ProdBits-1:0] p1_reg;

    always_ff @(posedge clk)
    begin
        p0_reg <= op.a * op.b;
        p1_reg <= op.c * op.d;
        result <= svet_pkg::DetBits'(p0_reg) - svet_pkg::DetBits'(p1_reg);
    end
endmodule
`default_nettype wire

// ===== hw/rtl/segment_vs_edge_table_intersect.sv =====
// ============================================================================
// segment_vs_edge_table_intersect - query segment against a stored edge list
// Vertex store, edge list, and a sequencer around one cross-product unit.
// ============================================================================
// Usage: one transfer in gives exactly one transfer out. A vertex write, an
// edge append or a clear presents its result on the cycle after its transfer.
// A query walks the edge list in order and stops on the first crossing. Each
// edge visited goes through store reads (one edge-store read, then two
// vertex-store reads on the single read port and one wait for the second
// vertex), three products d, tn and un through the one shared
// multiply-subtract unit, and one check. The vertex read port and the
// multiplier set the pace of a query. The block takes no new item while a
// query runs or a result waits to be taken. The crossing test is exact: with
// d = det, tn and un, the edge is hit when d != 0 and both tn and un lie
// between 0 and d inclusive, compared with their signs, no division.
// ============================================================================
`default_nettype none
module segment_vs_edge_table_intersect (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire svet_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output svet_pkg::out_item_t      out_data
);
    localparam int DB = svet_pkg::DiffBits;
    localparam int CB = svet_pkg::CoordBits;
    localparam int VB = svet_pkg::VIdxBits;
    localparam int EB = svet_pkg::EIdxBits;
    localparam int NB = svet_pkg::CntBits;
    localparam int TB = svet_pkg::DetBits;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_ERD   = 10'b0000000010,
        ST_VA    = 10'b0000000100,
        ST_VB    = 10'b0000001000,
        ST_VBW   = 10'b0000010000,
        ST_MD    = 10'b0000100000,
        ST_MT    = 10'b0001000000,
        ST_MU    = 10'b0010000000,
        ST_CHK   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [NB-1:0] total_reg, total_next;
    logic [NB-1:0] k_reg, k_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    svet_pkg::out_item_t out_reg, out_next;

    logic signed [CB-1:0] qx1_reg, qz1_reg, qx2_reg, qz2_reg;
    logic signed [CB-1:0] x3_reg, z3_reg, x4_reg, z4_reg;
    logic [VB-1:0]        eb_idx_reg;
    logic signed [TB-1:0] det_reg, tn_reg;

    logic in_fire;
    assign in_stall  = out_valid_reg || (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // stores
    logic                    v_we;
    logic [VB-1:0]           v_raddr;
    logic [2*CB-1:0]         v_rdata;
    logic                    e_we;
    logic [2*VB-1:0]         e_rdata;

    assign v_we = in_fire && (svet_pkg::req_type_t'(in_data.req_type)
                              == svet_pkg::REQ_WRITE_VERTEX);
    assign e_we = in_fire && (svet_pkg::req_type_t'(in_data.req_type)
                              == svet_pkg::REQ_APPEND_EDGE)
                          && (total_reg < NB'(svet_pkg::MaxEdges));

    svet_ram #(.Width(2 * CB), .Depth(svet_pkg::MaxVertices)) u_vram (
        .clk     (clk),
        .wr_en   (v_we),
        .wr_addr (in_data.vertex_index[VB-1:0]),
        .wr_data ({in_data.vertex_x[CB-1:0], in_data.vertex_z[CB-1:0]}),
        .rd_addr (v_raddr),
        .rd_data (v_rdata)
    );

    svet_ram #(.Width(2 * VB), .Depth(svet_pkg::MaxEdges)) u_eram (
        .clk     (clk),
        .wr_en   (e_we),
        .wr_addr (total_reg[EB-1:0]),
        .wr_data ({in_data.edge_first[VB-1:0], in_data.edge_second[VB-1:0]}),
        .rd_addr (k_reg[EB-1:0]),
        .rd_data (e_rdata)
    );

    // shared multiply-subtract unit
    svet_pkg::mac_op_t    mop;
    logic signed [TB-1:0] mres;
    logic signed [DB-1:0] adx, adz, bdx, bdz, sdx, sdz;

    assign adx = DB'(qx1_reg) - DB'(qx2_reg);
    assign adz = DB'(qz1_reg) - DB'(qz2_reg);
    assign bdx = DB'(x3_reg) - DB'(x4_reg);
    assign bdz = DB'(z3_reg) - DB'(z4_reg);
    assign sdx = DB'(qx1_reg) - DB'(x3_reg);
    assign sdz = DB'(qz1_reg) - DB'(z3_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_MD:   mop = '{a: adx, b: bdz, c: adz, d: bdx};
            ST_MT:   mop = '{a: sdx, b: bdz, c: sdz, d: bdx};
            default: mop = '{a: adz, b: sdx, c: adx, d: sdz};
        endcase
    end

    svet_mac u_mac (
        .clk    (clk),
        .op     (mop),
        .result (mres)
    );

    function automatic logic within_unit(logic signed [TB-1:0] num,
                                         logic signed [TB-1:0] den);
        if (den > 0)
            return (num >= 0) && (num <= den);
        return (num <= 0) && (num >= den);
    endfunction

    assign v_raddr = (state_reg == ST_VA) ? e_rdata[2*VB-1:VB] : eb_idx_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            qx1_reg <= in_data.query_start_x[CB-1:0];
            qz1_reg <= in_data.query_start_z[CB-1:0];
            qx2_reg <= in_data.query_end_x[CB-1:0];
            qz2_reg <= in_data.query_end_z[CB-1:0];
        end
        if (state_reg == ST_VA)
        begin
            eb_idx_reg <= e_rdata[VB-1:0];
        end
        // first vertex data arrives the cycle after its address
        if (state_reg == ST_VB)
        begin
            x3_reg <= v_rdata[2*CB-1:CB];
            z3_reg <= v_rdata[CB-1:0];
        end
        if (state_reg == ST_MD && cnt_reg == 2'd0)
        begin
            x4_reg <= v_rdata[2*CB-1:CB];
            z4_reg <= v_rdata[CB-1:0];
        end
        if (state_reg == ST_MT && cnt_reg == 2'd0)
        begin
            det_reg <= mres;
        end
        if (state_reg == ST_MU && cnt_reg == 2'd0)
        begin
            tn_reg <= mres;
        end
    end

    // sequencer: ST_MD first latches the second vertex, and each product
    // stage holds its operands to the shared unit until cnt reaches 3.
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hit_next = 1'b0;
                    k_next   = '0;
                    unique case (svet_pkg::req_type_t'(in_data.req_type))
                        svet_pkg::REQ_WRITE_VERTEX:
                        begin
                            out_next = '{status: 1'b0, hit: 1'b0,
                                         edges_held: 11'(total_reg)};
                            out_valid_next = 1'b1;
                        end
                        svet_pkg::REQ_APPEND_EDGE:
                        begin
                            if (total_reg < NB'(svet_pkg::MaxEdges))
                            begin
                                total_next = total_reg + 1'b1;
                                out_next = '{status: 1'b0, hit: 1'b0,
                                             edges_held: 11'(total_reg + 1'b1)};
                            end
                            else
                            begin
                                out_next = '{status: 1'b1, hit: 1'b0,
                                             edges_held: 11'(total_reg)};
                            end
                            out_valid_next = 1'b1;
                        end
                        svet_pkg::REQ_CLEAR_EDGES:
                        begin
                            total_next = '0;
                            out_next = '{status: 1'b0, hit: 1'b0, edges_held: '0};
                            out_valid_next = 1'b1;
                        end
                        svet_pkg::REQ_QUERY:
                        begin
                            state_next = (total_reg == '0) ? ST_DONE : ST_ERD;
                        end
                    endcase
                end
            end
            ST_ERD:  state_next = ST_VA;   // edge read in flight
            ST_VA:   state_next = ST_VB;   // first vertex address issued
            ST_VB:   state_next = ST_VBW;  // second vertex address issued
            ST_VBW:
            begin
                state_next = ST_MD;
                cnt_next   = 2'd0;
            end
            ST_MD, ST_MT, ST_MU:
            begin
                // cnt 0: operands settle; 1,2,3: pipeline of the unit
                if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    unique case (state_reg)
                        ST_MD:   state_next = ST_MT;
                        ST_MT:   state_next = ST_MU;
                        default: state_next = ST_CHK;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_CHK:
            begin
                if ((det_reg != '0) && within_unit(tn_reg, det_reg)
                    && within_unit(mres, det_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (k_reg + 1'b1 >= total_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_DONE:
            begin
                out_next = '{status: 1'b0, hit: hit_reg, edges_held: 11'(total_reg)};
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule
`default_nettype wire
